### sv/lsfe_pkg.sv
// lsfe_pkg: shared types, constants and helper functions for the led strip
// frame encoder. No dependencies; imported by lsfe_ctrl, lsfe_datapath and the top level.
package lsfe_pkg;

	localparam int MAX_LEDS_DEF = 64;
	localparam int COLOUR_W     = 24;
	localparam int LEVEL_W      = 8;
	localparam int WAVE_W       = 64;
	localparam int LED_COUNT_W  = 7;
	localparam int LED_INDEX_W  = 6;

	localparam logic [LEVEL_W-1:0] WAVE_ZERO  = 8'hC0;
	localparam logic [LEVEL_W-1:0] WAVE_ONE   = 8'hFC;
	localparam logic [LEVEL_W-1:0] FULL_SCALE = 8'd255;

	localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 7'd1;

	typedef enum logic {
		REG_LED_COUNT  = 1'b0,
		REG_BRIGHTNESS = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_SET_ONE = 1'b0,
		CMD_SET_ALL = 1'b1
	} led_cmd_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_SWEEP = 1'b1
	} ctrl_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;   // input transaction taken, latch colour
		logic wr_one;   // write the addressed led from the input ports
		logic err;      // inject an out-of-range result
		logic rd_en;    // issue one led of the sweep
		logic fill;     // sweep belongs to a set-all: write and bypass
		logic last;     // issued led is the final one
	} ctl_cmd_t;

	// floor(x / 255) for x up to 255*255
	function automatic logic [LEVEL_W-1:0] div_full_scale(input logic [2*LEVEL_W-1:0] x);
		logic [2*LEVEL_W:0] sum;
		sum = {1'b0, x} + {9'd0, x[2*LEVEL_W-1:LEVEL_W]} + 17'd1;
		return sum[2*LEVEL_W-1:LEVEL_W];
	endfunction

	// each colour bit becomes one spi byte, msb first in the top byte
	function automatic logic [WAVE_W-1:0] encode_wave(input logic [LEVEL_W-1:0] level);
		logic [WAVE_W-1:0] w;
		w = '0;
		for (int b = 0; b < LEVEL_W; b++) begin
			w[b*8 +: 8] = level[b] ? WAVE_ONE : WAVE_ZERO;
		end
		return w;
	endfunction

endpackage

### sv/lsfe_ctrl.sv
// lsfe_ctrl: controller state machine for the led strip frame encoder.
// Decodes commands and sequences the led sweep. Depends on lsfe_pkg.
module lsfe_ctrl #(
	parameter int MAX_LEDS = lsfe_pkg::MAX_LEDS_DEF,
	parameter int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1,
	parameter int CW = $clog2(MAX_LEDS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  cmd,
	input  logic [CW-1:0]         count,
	input  logic                  idx_ok,
	output logic                  busy,
	output lsfe_pkg::ctl_cmd_t    ctl,
	output logic [AW-1:0]         addr
);
	import lsfe_pkg::*;

	ctrl_state_t      state_q, state_n;
	logic [AW-1:0]    addr_q, addr_n;
	logic [CW-1:0]    count_q, count_n;
	logic             fill_q, fill_n;
	logic [CW-1:0]    issued_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			count_q <= CW'(1);
			fill_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			addr_q  <= addr_n;
			count_q <= count_n;
			fill_q  <= fill_n;
		end
	end

	assign issued_n = CW'(addr_q) + CW'(1);

	always_comb begin
		state_n = state_q;
		addr_n  = addr_q;
		count_n = count_q;
		fill_n  = fill_q;
		ctl     = '0;
		busy    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					count_n    = count;
					addr_n     = '0;
					if (led_cmd_t'(cmd) == CMD_SET_ALL) begin
						fill_n  = 1'b1;
						state_n = ST_SWEEP;
					end else if (idx_ok) begin
						ctl.wr_one = 1'b1;
						fill_n     = 1'b0;
						state_n    = ST_SWEEP;
					end else begin
						ctl.err  = 1'b1;
						ctl.last = 1'b1;
					end
				end
			end
			ST_SWEEP: begin
				busy      = 1'b1;
				ctl.rd_en = 1'b1;
				ctl.fill  = fill_q;
				ctl.last  = (issued_n == count_q);
				if (ctl.last) begin
					state_n = ST_IDLE;
					addr_n  = '0;
				end else begin
					addr_n = addr_q + AW'(1);
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign addr = addr_q;

`ifndef ASSERT_OFF
	a_last_ends_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.rd_en && ctl.last) |=> (state_q == ST_IDLE))
		else $error("sweep did not end after its last led");
	a_addr_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |-> (CW'(addr_q) < count_q))
		else $error("sweep address beyond latched count");
	a_no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!ctl.wr_one && !ctl.accept && !ctl.err))
		else $error("command decoded while sweep in progress");
`endif

endmodule

### sv/lsfe_datapath.sv
// lsfe_datapath: config registers, colour store, scaling pipeline and wave encoding.
// Driven by lsfe_ctrl commands. Depends on lsfe_pkg.
module lsfe_datapath #(
	parameter int MAX_LEDS = lsfe_pkg::MAX_LEDS_DEF,
	parameter int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1,
	parameter int CW = $clog2(MAX_LEDS + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [lsfe_pkg::LEVEL_W-1:0]         cfg_data,
	input  lsfe_pkg::ctl_cmd_t                   ctl,
	input  logic [AW-1:0]                        addr,
	input  logic [lsfe_pkg::LED_INDEX_W-1:0]     led_index,
	input  logic [lsfe_pkg::LEVEL_W-1:0]         red_level,
	input  logic [lsfe_pkg::LEVEL_W-1:0]         green_level,
	input  logic [lsfe_pkg::LEVEL_W-1:0]         blue_level,
	output logic [CW-1:0]                        count,
	output logic                                 idx_ok,
	output logic                                 strobe,
	output logic [lsfe_pkg::WAVE_W-1:0]          green_wave,
	output logic [lsfe_pkg::WAVE_W-1:0]          red_wave,
	output logic [lsfe_pkg::WAVE_W-1:0]          blue_wave,
	output logic                                 last_led,
	output logic                                 status
);
	import lsfe_pkg::*;

	logic [LED_COUNT_W-1:0] led_count_q;
	logic [LEVEL_W-1:0]     bright_q;
	logic [COLOUR_W-1:0]    colour_q;

	logic [COLOUR_W-1:0]    mem [MAX_LEDS];
	logic [MAX_LEDS-1:0]    valid_q;

	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [COLOUR_W-1:0]    wr_data;

	logic                   valid_s1, last_s1, err_s1, fill_s1, vld_s1;
	logic [COLOUR_W-1:0]    rdata_s1, fillc_s1, colour_s1;

	logic                   valid_s2, last_s2, err_s2;
	logic [2*LEVEL_W-1:0]   prod_r_s2, prod_g_s2, prod_b_s2;

	logic                   strobe_q, last_q, status_q;
	logic [WAVE_W-1:0]      gw_q, rw_q, bw_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LED_COUNT_RST;
			bright_q    <= FULL_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LED_COUNT:  led_count_q <= cfg_data[LED_COUNT_W-1:0];
				REG_BRIGHTNESS: bright_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp led count to 1..MAX_LEDS
	always_comb begin
		priority if (led_count_q == '0)
			count = CW'(1);
		else if (led_count_q > LED_COUNT_W'(MAX_LEDS))
			count = CW'(MAX_LEDS);
		else
			count = led_count_q[CW-1:0];
	end

	assign idx_ok = LED_COUNT_W'(led_index) < LED_COUNT_W'(count);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			colour_q <= {red_level, green_level, blue_level};
		end
	end

	// single write port shared by set-one and the set-all sweep
	assign wr_en   = ctl.wr_one | (ctl.rd_en & ctl.fill);
	assign wr_addr = ctl.fill ? addr : led_index[AW-1:0];
	assign wr_data = ctl.fill ? colour_q : {red_level, green_level, blue_level};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[addr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= ctl.rd_en | ctl.err;
			valid_s2 <= valid_s1;
			strobe_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s1  <= ctl.last;
		err_s1   <= ctl.err;
		fill_s1  <= ctl.fill;
		fillc_s1 <= colour_q;
		vld_s1   <= valid_q[addr];
	end

	always_comb begin
		priority if (fill_s1)
			colour_s1 = fillc_s1;
		else if (vld_s1)
			colour_s1 = rdata_s1;
		else
			colour_s1 = '0;
	end

	always_ff @(posedge clk) begin
		last_s2   <= last_s1;
		err_s2    <= err_s1;
		prod_r_s2 <= {{LEVEL_W{1'b0}}, colour_s1[23:16]} * {{LEVEL_W{1'b0}}, bright_q};
		prod_g_s2 <= {{LEVEL_W{1'b0}}, colour_s1[15:8]} * {{LEVEL_W{1'b0}}, bright_q};
		prod_b_s2 <= {{LEVEL_W{1'b0}}, colour_s1[7:0]} * {{LEVEL_W{1'b0}}, bright_q};
	end

	always_ff @(posedge clk) begin
		last_q   <= last_s2;
		status_q <= err_s2;
		gw_q     <= err_s2 ? '0 : encode_wave(div_full_scale(prod_g_s2));
		rw_q     <= err_s2 ? '0 : encode_wave(div_full_scale(prod_r_s2));
		bw_q     <= err_s2 ? '0 : encode_wave(div_full_scale(prod_b_s2));
	end

	assign strobe     = strobe_q;
	assign green_wave = gw_q;
	assign red_wave   = rw_q;
	assign blue_wave  = bw_q;
	assign last_led   = last_q;
	assign status     = status_q;

`ifndef ASSERT_OFF
	a_token_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ##2 strobe_q)
		else $error("pipeline token lost");
	a_err_no_wave: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && status_q) |-> (last_q && gw_q == '0 && rw_q == '0 && bw_q == '0))
		else $error("error result carries waves");
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.wr_one && ctl.rd_en))
		else $error("two writers on the colour store");
`endif

endmodule

### sv/led_strip_frame_encoder_core.sv
// led_strip_frame_encoder_core: top level; set-one and set-all commands, one
// result per led, last result flagged; an out-of-range index gives one error result.
// Results pass the sweep state, s1, s2 and output registers; errors skip the sweep.
// Commands are taken only in the idle state; the sweep issues one led per memory read.
// Results cannot be stalled; the strobe holds each for one cycle.
// Reset: asynchronous, clears state, valid bits and config (led_count 1, brightness 255).
module led_strip_frame_encoder_core #(
	parameter int MAX_LEDS = lsfe_pkg::MAX_LEDS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [lsfe_pkg::LEVEL_W-1:0]         cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 cmd,
	input  logic [lsfe_pkg::LED_INDEX_W-1:0]     led_index,
	input  logic [lsfe_pkg::LEVEL_W-1:0]         red_level,
	input  logic [lsfe_pkg::LEVEL_W-1:0]         green_level,
	input  logic [lsfe_pkg::LEVEL_W-1:0]         blue_level,
	output logic                                 strobe,
	output logic [lsfe_pkg::WAVE_W-1:0]          green_wave,
	output logic [lsfe_pkg::WAVE_W-1:0]          red_wave,
	output logic [lsfe_pkg::WAVE_W-1:0]          blue_wave,
	output logic                                 last_led,
	output logic                                 status
);
	import lsfe_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int CW = $clog2(MAX_LEDS + 1);

	ctl_cmd_t       ctl;
	logic [AW-1:0]  addr;
	logic [CW-1:0]  count;
	logic           idx_ok;

	lsfe_ctrl #(
		.MAX_LEDS (MAX_LEDS),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.count  (count),
		.idx_ok (idx_ok),
		.busy   (busy),
		.ctl    (ctl),
		.addr   (addr)
	);

	lsfe_datapath #(
		.MAX_LEDS (MAX_LEDS),
		.AW       (AW),
		.CW       (CW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.ctl         (ctl),
		.addr        (addr),
		.led_index   (led_index),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.count       (count),
		.idx_ok      (idx_ok),
		.strobe      (strobe),
		.green_wave  (green_wave),
		.red_wave    (red_wave),
		.blue_wave   (blue_wave),
		.last_led    (last_led),
		.status      (status)
	);

endmodule
